// File: src/gspc_pkg.sv
// ----------------------------------------------------------------------------
// gspc_pkg
// Shared types, constants and exp table helpers for the splat compositor.
// ----------------------------------------------------------------------------
package gspc_pkg;

    // default sizes handed to the top level parameters
    localparam int unsigned EXP_ENTRIES_DEF = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // fixed point constants
    localparam logic [16:0] T_ONE     = 17'h10000;   // 1.0 in Q1.16
    localparam logic [15:0] ALPHA_CAP = 16'd64881;   // 0.99 in Q0.16
    localparam logic [15:0] ALPHA_MIN = 16'd258;     // smallest alpha with alpha*255 >= 2^16
    localparam logic [16:0] T_MIN     = 17'd7;       // smallest T with T*10000 >= 2^16
    localparam logic [17:0] ACC_MAX   = 18'h3FFFF;
    localparam logic [15:0] OUT_MAX   = 16'hFFFF;
    localparam int unsigned Q_FRAC    = 28;          // q range covered by the exp table

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BG_RED   = 2'd0,
        CFG_BG_GREEN = 2'd1,
        CFG_BG_BLUE  = 2'd2
    } gspc_cfg_index_t;

    // back part sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BLEND,
        BK_FINISH
    } gspc_bk_state_t;

    // background color
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } gspc_bg_t;

    // splat fields carried along the front pipeline
    typedef struct packed {
        logic [15:0] opacity;
        logic [15:0] color_red;
        logic [15:0] color_green;
        logic [15:0] color_blue;
        logic        last;
    } gspc_side_t;

    // classified splat handed from front to back
    typedef struct packed {
        logic        skip;
        logic [15:0] alpha;
        logic [15:0] color_red;
        logic [15:0] color_green;
        logic [15:0] color_blue;
        logic        last;
    } gspc_item_t;

    // per-entry ratio exp(-8/N) in Q31 from a 13 term series
    function automatic logic [63:0] gspc_exp_ratio(input logic [63:0] step);
        logic [63:0]        term;
        logic signed [63:0] r;
        term = 64'd1 << 31;
        r    = 64'sd1 <<< 31;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * step) >> 31) / 64'(n);
            if ((n % 2) == 1) begin
                r = r - $signed(term);
            end else begin
                r = r + $signed(term);
            end
        end
        if (r < 0) begin
            r = 64'sd0;
        end
        return $unsigned(r);
    endfunction

    // table entry k: ratio^k in Q31, rounded to Q1.16
    function automatic logic [16:0] gspc_exp_entry(input int unsigned k,
                                                   input logic [63:0] ratio);
        logic [63:0] e;
        e = 64'd1 << 31;
        for (int unsigned i = 0; i < k; i++) begin
            e = (e * ratio) >> 31;
        end
        return 17'((e + (64'd1 << 14)) >> 15);
    endfunction

endpackage

// File: src/gaussian_splat_pixel_compositor.sv
// ----------------------------------------------------------------------------
// gaussian_splat_pixel_compositor
// Front-to-back alpha blending of depth-sorted Gaussian splats for one pixel.
// ----------------------------------------------------------------------------
//
// channel   direction  transaction                          payload
// s_*       in         one splat, tlast ends the pixel      200-bit tdata
// m_*       out        one finished pixel per last splat    48-bit tdata
// cfg_*     in         background color write, no wait      16-bit data
//
// in the blender, IDLE registers a splat's transmittance products and BLEND does
// the accumulate and T update; the last splat of a pixel then goes through
// FINISH for the background term. the evaluation pipeline is registered and
// runs ahead through a small queue. no clearing pass after reset. a held
// result stalls the blender at the next pixel's last splat; the input stops
// once the queue is full and a splat waits in the pipeline's last stage.
//
module gaussian_splat_pixel_compositor #(
    parameter int unsigned EXP_TABLE_ENTRIES = gspc_pkg::EXP_ENTRIES_DEF,
    parameter int unsigned QUEUE_DEPTH       = gspc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // splat in
    input  logic         s_tvalid,
    output logic         s_tready,
    // pix_x, pix_y, mean_x, mean_y, conic_xx, conic_xy, conic_yy, opacity,
    // color_red, color_green, color_blue, zero pad
    input  logic [199:0] s_tdata,
    input  logic         s_tlast,   // last_splat
    // pixel out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // out_red, out_green, out_blue
    // configuration
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wr_data
);
    import gspc_pkg::*;

    gspc_bg_t   bg_reg;
    gspc_side_t in_side;
    gspc_item_t fr_item, bk_item;
    logic       fr_valid, fr_ready, bk_valid, bk_pop;

    // background registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (gspc_cfg_index_t'(cfg_index))
                CFG_BG_RED:   bg_reg.red   <= cfg_wr_data;
                CFG_BG_GREEN: bg_reg.green <= cfg_wr_data;
                CFG_BG_BLUE:  bg_reg.blue  <= cfg_wr_data;
                default:      ;
            endcase
        end
    end

    // splat fields that ride along the pipeline
    assign in_side.opacity     = s_tdata[147:132];
    assign in_side.color_red   = s_tdata[163:148];
    assign in_side.color_green = s_tdata[179:164];
    assign in_side.color_blue  = s_tdata[195:180];
    assign in_side.last        = s_tlast;

    gspc_front #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pix_x     (s_tdata[11:0]),
        .pix_y     (s_tdata[23:12]),
        .mean_x    ($signed(s_tdata[41:24])),
        .mean_y    ($signed(s_tdata[59:42])),
        .conic_xx  ($signed(s_tdata[83:60])),
        .conic_xy  ($signed(s_tdata[107:84])),
        .conic_yy  ($signed(s_tdata[131:108])),
        .in_side   (in_side),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    gspc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (bk_valid),
        .out_pop   (bk_pop),
        .out_item  (bk_item)
    );

    gspc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bg         (bg_reg),
        .item_valid (bk_valid),
        .item_pop   (bk_pop),
        .item       (bk_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: src/gspc_front.sv
// ----------------------------------------------------------------------------
// gspc_front
// Splat evaluation pipeline: offset, quadratic form, exp lookup and alpha.
// ----------------------------------------------------------------------------
module gspc_front #(
    parameter int unsigned EXP_TABLE_ENTRIES = gspc_pkg::EXP_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // splat in
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [11:0]         pix_x,
    input  logic [11:0]         pix_y,
    input  logic signed [17:0]  mean_x,
    input  logic signed [17:0]  mean_y,
    input  logic signed [23:0]  conic_xx,
    input  logic signed [23:0]  conic_xy,
    input  logic signed [23:0]  conic_yy,
    input  gspc_pkg::gspc_side_t in_side,
    // classified splat out
    output logic                out_valid,
    input  logic                out_ready,
    output gspc_pkg::gspc_item_t out_item
);
    import gspc_pkg::*;

    localparam int unsigned IW = (EXP_TABLE_ENTRIES > 1) ? $clog2(EXP_TABLE_ENTRIES) : 1;
    localparam int unsigned NW = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam logic [63:0] ExpStep  = 64'((64'd1 << 34) / EXP_TABLE_ENTRIES);
    localparam logic [63:0] ExpRatio = gspc_exp_ratio(ExpStep);
    localparam int unsigned STAGES = 7;

    // exp table as constant logic
    logic [16:0] exp_rom [EXP_TABLE_ENTRIES];
    for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_rom
        assign exp_rom[g] = gspc_exp_entry(g, ExpRatio);
    end

    logic                adv;
    logic [STAGES-1:0]   vld_reg;

    // stage registers
    logic signed [18:0]  dx1_reg, dy1_reg;
    logic signed [24:0]  c1_reg [3];
    gspc_side_t          side1_reg;
    logic signed [37:0]  v2_reg [3];
    logic signed [24:0]  c2_reg [3];
    gspc_side_t          side2_reg;
    logic signed [44:0]  plo3_reg [3];
    logic signed [43:0]  phi3_reg [3];
    gspc_side_t          side3_reg;
    logic signed [63:0]  t4_reg [3];
    gspc_side_t          side4_reg;
    logic [Q_FRAC-1:0]   q5_reg;
    logic                skip5_reg;
    gspc_side_t          side5_reg;
    logic [IW-1:0]       k6_reg;
    logic                skip6_reg;
    gspc_side_t          side6_reg;
    logic [16:0]         e7_reg;
    logic                skip7_reg;
    gspc_side_t          side7_reg;

    // combinational terms
    logic signed [18:0]  mx, my, px, py;
    logic signed [63:0]  q_sum;
    logic [Q_FRAC+NW-1:0] k_prod;
    logic [32:0]         a_prod;
    logic [16:0]         a_raw;
    logic [15:0]         a_cap;

    // whole pipeline moves together unless the last stage is blocked
    assign adv      = !vld_reg[STAGES-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // pixel offset in 1/16 pixel
    always_comb begin
        mx = {mean_x[17], mean_x};
        my = {mean_y[17], mean_y};
        px = $signed({3'b000, pix_x, 4'b0000});
        py = $signed({3'b000, pix_y, 4'b0000});
    end

    // form sum, table index and alpha
    always_comb begin
        q_sum  = t4_reg[0] + t4_reg[1] + t4_reg[2];
        k_prod = (Q_FRAC + NW)'(q5_reg) * (Q_FRAC + NW)'(EXP_TABLE_ENTRIES);
        a_prod = {1'b0, side7_reg.opacity} * {16'd0, e7_reg};
        a_raw  = a_prod[32:16];
        a_cap  = (a_raw > {1'b0, ALPHA_CAP}) ? ALPHA_CAP : a_raw[15:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1: offsets, conic terms with the cross term doubled
            dx1_reg   <= mx - px;
            dy1_reg   <= my - py;
            c1_reg[0] <= {conic_xx[23], conic_xx};
            c1_reg[1] <= {conic_xy, 1'b0};
            c1_reg[2] <= {conic_yy[23], conic_yy};
            side1_reg <= in_side;
            // stage 2: offset products
            v2_reg[0] <= dx1_reg * dx1_reg;
            v2_reg[1] <= dx1_reg * dy1_reg;
            v2_reg[2] <= dy1_reg * dy1_reg;
            c2_reg    <= c1_reg;
            side2_reg <= side1_reg;
            // stage 3: split conic products into low and high halves
            for (int i = 0; i < 3; i++) begin
                plo3_reg[i] <= c2_reg[i] * $signed({1'b0, v2_reg[i][18:0]});
                phi3_reg[i] <= c2_reg[i] * $signed(v2_reg[i][37:19]);
            end
            side3_reg <= side2_reg;
            // stage 4: recombine each term
            for (int i = 0; i < 3; i++) begin
                t4_reg[i] <= ({{20{phi3_reg[i][43]}}, phi3_reg[i]} <<< 19)
                           + {{19{plo3_reg[i][44]}}, plo3_reg[i]};
            end
            side4_reg <= side3_reg;
            // stage 5: full form, skip on positive power or past table range
            q5_reg    <= q_sum[Q_FRAC-1:0];
            skip5_reg <= q_sum[63] || (|q_sum[62:Q_FRAC]);
            side5_reg <= side4_reg;
            // stage 6: table index
            k6_reg    <= k_prod[Q_FRAC +: IW];
            skip6_reg <= skip5_reg;
            side6_reg <= side5_reg;
            // stage 7: table read
            e7_reg    <= exp_rom[k6_reg];
            skip7_reg <= skip6_reg;
            side7_reg <= side6_reg;
        end
    end

    // classified splat
    assign out_valid            = vld_reg[STAGES-1];
    assign out_item.skip        = skip7_reg || (a_cap < ALPHA_MIN);
    assign out_item.alpha       = a_cap;
    assign out_item.color_red   = side7_reg.color_red;
    assign out_item.color_green = side7_reg.color_green;
    assign out_item.color_blue  = side7_reg.color_blue;
    assign out_item.last        = side7_reg.last;

endmodule

// File: src/gspc_queue.sv
// ----------------------------------------------------------------------------
// gspc_queue
// Small register queue between the evaluation pipeline and the blender.
// ----------------------------------------------------------------------------
module gspc_queue #(
    parameter int unsigned DEPTH = gspc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gspc_pkg::gspc_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_pop,
    output gspc_pkg::gspc_item_t out_item
);
    import gspc_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    gspc_item_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_item  = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: src/gspc_back.sv
// ----------------------------------------------------------------------------
// gspc_back
// Front-to-back blender: transmittance loop, color accumulators, pixel output.
// ----------------------------------------------------------------------------
module gspc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gspc_pkg::gspc_bg_t   bg,
    input  logic                 item_valid,
    output logic                 item_pop,
    input  gspc_pkg::gspc_item_t item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata
);
    import gspc_pkg::*;

    gspc_bk_state_t state_reg, state_next;

    logic [16:0] t_reg;
    logic [17:0] acc_red_reg, acc_green_reg, acc_blue_reg;
    logic        done_reg;
    logic [16:0] test_t_reg, w_reg;
    gspc_item_t  cur_reg;
    logic        m_valid_reg;
    logic [47:0] out_data_reg;

    logic        out_free, blend_step, load_out, blend_en;
    logic [16:0] keep_frac;
    logic [33:0] keep_prod, w_prod;
    logic [16:0] test_t_next, w_next;
    logic [17:0] acc_red_next, acc_green_next, acc_blue_next;
    logic [15:0] out_red_next, out_green_next, out_blue_next;

    // saturating accumulate of w * color
    function automatic logic [17:0] acc_step(input logic [17:0] acc,
                                             input logic [16:0] w,
                                             input logic [15:0] color);
        logic [32:0] p;
        logic [18:0] s;
        p = {16'd0, w} * {17'd0, color};
        s = {1'b0, acc} + {2'b00, p[32:16]};
        return (s > {1'b0, ACC_MAX}) ? ACC_MAX : s[17:0];
    endfunction

    // background times transmittance plus accumulated color, saturated
    function automatic logic [15:0] pix_out(input logic [15:0] b,
                                            input logic [16:0] t,
                                            input logic [17:0] acc);
        logic [32:0] p;
        logic [18:0] s;
        p = {17'd0, b} * {16'd0, t};
        s = {2'b00, p[32:16]} + {1'b0, acc};
        return (s > {3'b000, OUT_MAX}) ? OUT_MAX : s[15:0];
    endfunction

    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (item_valid) state_next = BK_BLEND;
            BK_BLEND:  state_next = cur_reg.last ? BK_FINISH : BK_IDLE;
            BK_FINISH: if (out_free) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        item_pop   = 1'b0;
        blend_step = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE:   item_pop   = item_valid;
            BK_BLEND:  blend_step = 1'b1;
            BK_FINISH: load_out   = out_free;
            default:   ;
        endcase
    end

    // products against the current transmittance
    always_comb begin
        keep_frac   = T_ONE - {1'b0, item.alpha};
        keep_prod   = {17'd0, t_reg} * {17'd0, keep_frac};
        w_prod      = {17'd0, t_reg} * {18'd0, item.alpha};
        test_t_next = keep_prod[32:16];
        w_next      = w_prod[32:16];
    end

    // blend and output values
    always_comb begin
        blend_en       = !done_reg && !cur_reg.skip;
        acc_red_next   = acc_step(acc_red_reg, w_reg, cur_reg.color_red);
        acc_green_next = acc_step(acc_green_reg, w_reg, cur_reg.color_green);
        acc_blue_next  = acc_step(acc_blue_reg, w_reg, cur_reg.color_blue);
        out_red_next   = pix_out(bg.red, t_reg, acc_red_reg);
        out_green_next = pix_out(bg.green, t_reg, acc_green_reg);
        out_blue_next  = pix_out(bg.blue, t_reg, acc_blue_reg);
    end

    // pixel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            t_reg         <= T_ONE;
            acc_red_reg   <= '0;
            acc_green_reg <= '0;
            acc_blue_reg  <= '0;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (blend_step && blend_en) begin
                if (test_t_reg < T_MIN) begin
                    done_reg <= 1'b1;
                end else begin
                    t_reg         <= test_t_reg;
                    acc_red_reg   <= acc_red_next;
                    acc_green_reg <= acc_green_next;
                    acc_blue_reg  <= acc_blue_next;
                end
            end
            if (load_out) begin
                t_reg         <= T_ONE;
                acc_red_reg   <= '0;
                acc_green_reg <= '0;
                acc_blue_reg  <= '0;
                done_reg      <= 1'b0;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (item_pop) begin
            test_t_reg <= test_t_next;
            w_reg      <= w_next;
            cur_reg    <= item;
        end
        if (load_out) begin
            out_data_reg <= {out_blue_next, out_green_next, out_red_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives depth-sorted splat streams into the pixel compositor and checks each
// finished pixel against a fixed-point blending model in step with it or a hand-computed value.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gspc_pkg::*;

    localparam int LUT_N         = gspc_pkg::EXP_ENTRIES_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 235;
    localparam int NUM_PHASES    = 6;

    // blending constants, Q0.16
    localparam longint Q16_ONE   = 65536;
    localparam longint ALPHA_TOP = 64881;
    localparam longint ACC_TOP   = 262143;
    localparam longint PIX_TOP   = 65535;

    // register index that decodes to nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [17:0] mean_x;
        logic [17:0] mean_y;
        logic [23:0] conic_xx;
        logic [23:0] conic_xy;
        logic [23:0] conic_yy;
        logic [15:0] opacity;
        logic [15:0] color_red;
        logic [15:0] color_green;
        logic [15:0] color_blue;
        logic        last;
    } splat_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } rgb_t;

    typedef enum {ROW_SPLAT, ROW_BG} row_kind_t;

    // directed stimulus row: a splat (with optional hand-computed pixel) or a
    // background write
    typedef struct {
        row_kind_t kind;
        splat_t    sp;
        bit        has_want;
        rgb_t      rgb;
    } row_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata     = '0;
    logic         s_tlast     = 1'b0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [47:0]  m_tdata;
    logic         cfg_wr_en   = 1'b0;
    logic [1:0]   cfg_index   = '0;
    logic [15:0]  cfg_wr_data = '0;

    // blending model state
    logic [16:0] exp_lut [LUT_N];
    logic [16:0] trans;
    logic [17:0] acc_red, acc_green, acc_blue;
    bit          pix_done;
    rgb_t        bg_model;

    rgb_t pending_pixels [$];
    row_t rows [$];
    int   fail_cnt     = 0;
    int   quiet_cycles = 0;
    bit   idle_on      = 1'b0;
    bit   hold_req     = 1'b0;

    gaussian_splat_pixel_compositor #(
        .EXP_TABLE_ENTRIES(LUT_N)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    // exp(-8k/N) table: 13-term series for one step, then repeated products
    function automatic void build_exp_lut();
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] e;
        longint      ratio;
        step  = (64'd1 << 34) / LUT_N;
        term  = 64'd1 << 31;
        ratio = longint'(1) << 31;
        for (int n = 1; n <= 12; n++) begin
            term  = ((term * step) >> 31) / 64'(n);
            ratio = (n % 2 == 1) ? ratio - longint'(term) : ratio + longint'(term);
        end
        if (ratio < 0) begin
            ratio = 0;
        end
        e = 64'd1 << 31;
        for (int k = 0; k < LUT_N; k++) begin
            exp_lut[k] = 17'((e + (64'd1 << 14)) >> 15);
            e = (e * 64'(ratio)) >> 31;
        end
    endfunction

    function automatic void clear_pixel();
        trans     = 17'(Q16_ONE);
        acc_red   = '0;
        acc_green = '0;
        acc_blue  = '0;
        pix_done  = 1'b0;
    endfunction

    function automatic logic [17:0] acc_add(logic [17:0] acc, logic [63:0] add);
        logic [63:0] sum;
        sum = 64'(acc) + add;
        return (sum > 64'(ACC_TOP)) ? 18'(ACC_TOP) : sum[17:0];
    endfunction

    // background weighted by final transmittance plus accumulated color
    function automatic logic [15:0] final_chan(logic [15:0] bg, logic [17:0] acc);
        logic [63:0] v;
        v = ((64'(bg) * 64'(trans)) >> 16) + 64'(acc);
        return (v > 64'(PIX_TOP)) ? 16'(PIX_TOP) : v[15:0];
    endfunction

    // one splat through the blender; returns 1 with the pixel on a last splat
    function automatic bit blend_splat(input splat_t sp, output rgb_t px);
        longint      dx, dy, cxx, cxy, cyy, q;
        logic [63:0] e, alpha, t_next, w;
        px = '0;
        if (!pix_done) begin
            dx  = longint'($signed(sp.mean_x)) - longint'(sp.pix_x) * 16;
            dy  = longint'($signed(sp.mean_y)) - longint'(sp.pix_y) * 16;
            cxx = longint'($signed(sp.conic_xx));
            cxy = longint'($signed(sp.conic_xy));
            cyy = longint'($signed(sp.conic_yy));
            q   = cxx * dx * dx + cyy * dy * dy + 2 * cxy * dx * dy;
            // positive power: splat has no effect
            if (q >= 0) begin
                if (q >= (longint'(1) << 28)) begin
                    e = '0;
                end else begin
                    e = 64'(exp_lut[int'((q * LUT_N) >> 28)]);
                end
                alpha = (64'(sp.opacity) * e) >> 16;
                if (alpha > 64'(ALPHA_TOP)) begin
                    alpha = 64'(ALPHA_TOP);
                end
                // faint splats are dropped
                if (alpha * 255 >= 64'(Q16_ONE)) begin
                    t_next = (64'(trans) * (64'(Q16_ONE) - alpha)) >> 16;
                    if (t_next * 10000 < 64'(Q16_ONE)) begin
                        pix_done = 1'b1;
                    end else begin
                        w         = (64'(trans) * alpha) >> 16;
                        acc_red   = acc_add(acc_red, (w * 64'(sp.color_red)) >> 16);
                        acc_green = acc_add(acc_green, (w * 64'(sp.color_green)) >> 16);
                        acc_blue  = acc_add(acc_blue, (w * 64'(sp.color_blue)) >> 16);
                        trans     = t_next[16:0];
                    end
                end
            end
        end
        if (!sp.last) begin
            return 1'b0;
        end
        px.red   = final_chan(bg_model.red, acc_red);
        px.green = final_chan(bg_model.green, acc_green);
        px.blue  = final_chan(bg_model.blue, acc_blue);
        clear_pixel();
        return 1'b1;
    endfunction

    function automatic splat_t mk_splat(int px, int py, int mx, int my, int cxx, int cxy,
                                        int cyy, int op, int r, int g, int b, bit last);
        splat_t s;
        s.pix_x       = 12'(px);
        s.pix_y       = 12'(py);
        s.mean_x      = 18'(mx);
        s.mean_y      = 18'(my);
        s.conic_xx    = 24'(cxx);
        s.conic_xy    = 24'(cxy);
        s.conic_yy    = 24'(cyy);
        s.opacity     = 16'(op);
        s.color_red   = 16'(r);
        s.color_green = 16'(g);
        s.color_blue  = 16'(b);
        s.last        = last;
        return s;
    endfunction

    function automatic rgb_t rgb(int r, int g, int b);
        return {16'(r), 16'(g), 16'(b)};
    endfunction

    function automatic row_t splat_row(splat_t sp);
        return '{ROW_SPLAT, sp, 1'b0, '0};
    endfunction

    function automatic row_t checked_row(splat_t sp, rgb_t want);
        return '{ROW_SPLAT, sp, 1'b1, want};
    endfunction

    function automatic row_t bg_row(rgb_t bg);
        return '{ROW_BG, '0, 1'b0, bg};
    endfunction

    // splat near the pixel with a sane conic, or now and then pure noise
    function automatic splat_t rand_splat(int px, int py, bit last);
        splat_t       s;
        logic [223:0] raw;
        if ($urandom_range(0, 4) == 0) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            s   = raw[$bits(splat_t)-1:0];
        end else begin
            s.pix_x       = 12'(px);
            s.pix_y       = 12'(py);
            s.mean_x      = 18'(px * 16 + $urandom_range(0, 128) - 64);
            s.mean_y      = 18'(py * 16 + $urandom_range(0, 128) - 64);
            s.conic_xx    = 24'($urandom_range(0, 131072));
            s.conic_xy    = 24'($urandom_range(0, 65536) - 32768);
            s.conic_yy    = 24'($urandom_range(0, 131072));
            s.opacity     = 16'($urandom_range(0, 1) ? $urandom_range(40000, 65535)
                                                     : $urandom_range(0, 65535));
            s.color_red   = 16'($urandom_range(0, 65535));
            s.color_green = 16'($urandom_range(0, 65535));
            s.color_blue  = 16'($urandom_range(0, 65535));
        end
        s.last = last;
        return s;
    endfunction

    // offer one splat, wait for the transaction, then update the model
    task automatic feed(input splat_t sp, input bit has_want, input rgb_t want);
        rgb_t px;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, sp.color_blue, sp.color_green, sp.color_red, sp.opacity,
                     sp.conic_yy, sp.conic_xy, sp.conic_xx, sp.mean_y, sp.mean_x,
                     sp.pix_y, sp.pix_x};
        s_tlast  <= sp.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (blend_splat(sp, px)) begin
            pending_pixels.push_back(has_want ? want : px);
        end
    endtask

    // stop sending, let every pixel come out and the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // background write, preceded by a write to the undecoded index
    task automatic write_bg(input rgb_t bg);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_UNUSED;
        cfg_wr_data <= 16'($urandom);
        @(posedge aclk);
        cfg_index   <= CFG_BG_RED;
        cfg_wr_data <= bg.red;
        @(posedge aclk);
        cfg_index   <= CFG_BG_GREEN;
        cfg_wr_data <= bg.green;
        @(posedge aclk);
        cfg_index   <= CFG_BG_BLUE;
        cfg_wr_data <= bg.blue;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        bg_model = bg;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each finished pixel with the oldest prediction
    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel transaction: %h", m_tdata);
                fail_cnt++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[15:0] !== want.red) begin
                    $error("out_red: expected %0d, got %0d", want.red, m_tdata[15:0]);
                    fail_cnt++;
                end
                if (m_tdata[31:16] !== want.green) begin
                    $error("out_green: expected %0d, got %0d", want.green, m_tdata[31:16]);
                    fail_cnt++;
                end
                if (m_tdata[47:32] !== want.blue) begin
                    $error("out_blue: expected %0d, got %0d", want.blue, m_tdata[47:32]);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int   sent;
        int   len;
        int   px;
        int   py;
        rgb_t bg;
        build_exp_lut();
        clear_pixel();
        bg_model = '0;

        // lone last splats, background at reset value
        rows.push_back(checked_row(mk_splat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1),
                                   rgb(0, 0, 0)));
        rows.push_back(checked_row(mk_splat(0, 0, 0, 0, 0, 0, 0, 65535, 65535, 65535,
                                            65535, 1), rgb(64880, 64880, 64880)));
        // positive power
        rows.push_back(checked_row(mk_splat(1, 0, 32, 0, -65536, 0, 0, 65535, 65535,
                                            65535, 65535, 1), rgb(0, 0, 0)));
        // transmittance runs out on the second splat, third is not evaluated
        rows.push_back(splat_row(mk_splat(5, 5, 80, 80, 0, 0, 0, 65535, 65535, 0, 32768, 0)));
        rows.push_back(splat_row(mk_splat(5, 5, 80, 80, 0, 0, 0, 65535, 1, 2, 3, 0)));
        rows.push_back(checked_row(mk_splat(5, 5, 80, 80, 0, 0, 0, 65535, 9, 9, 9, 1),
                                   rgb(64880, 0, 32440)));
        // extreme positions and conic, far outside the exp table
        rows.push_back(checked_row(mk_splat(4095, 4095, -131072, -131072, 8388607, 0,
                                            8388607, 65535, 65535, 65535, 65535, 1),
                                   rgb(0, 0, 0)));
        // cross term drives the form negative
        rows.push_back(checked_row(mk_splat(0, 0, 1000, 1000, 8388607, -8388608, 8388607,
                                            65535, 65535, 65535, 65535, 1), rgb(0, 0, 0)));
        // faint threshold, just below and just above
        rows.push_back(checked_row(mk_splat(0, 0, 0, 0, 0, 0, 0, 257, 65535, 65535, 65535,
                                            1), rgb(0, 0, 0)));
        rows.push_back(splat_row(mk_splat(0, 0, 0, 0, 0, 0, 0, 258, 65535, 65535, 65535, 0)));
        // half-power samples from the table, then a splat past its range
        rows.push_back(splat_row(mk_splat(2, 3, 48, 48, 65536, 0, 0, 50000, 1000, 30000,
                                          65535, 0)));
        rows.push_back(splat_row(mk_splat(2, 3, 32, 64, 0, -30000, 65536, 65535, 65535, 0,
                                          4000, 1)));
        rows.push_back(splat_row(mk_splat(4095, 0, 131071, 0, 1, 0, 0, 65535, 65535, 0, 0,
                                          1)));
        // full background
        rows.push_back(bg_row(rgb(65535, 65535, 65535)));
        rows.push_back(checked_row(mk_splat(7, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1),
                                   rgb(65535, 65535, 65535)));
        rows.push_back(splat_row(mk_splat(0, 0, 0, 0, 0, 0, 0, 65535, 65535, 65535, 65535,
                                          1)));
        rows.push_back(splat_row(mk_splat(9, 9, 150, 140, 40000, 2000, 60000, 30000, 65535,
                                          20000, 0, 1)));
        // mixed background
        rows.push_back(bg_row(rgb(12345, 0, 65535)));
        rows.push_back(splat_row(mk_splat(3, 4, 50, 60, 30000, -1000, 20000, 45000, 100,
                                          65535, 7000, 0)));
        rows.push_back(splat_row(mk_splat(3, 4, 40, 70, 90000, 500, 70000, 65535, 65535,
                                          300, 0, 1)));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        idle_on = 1'b1;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_BG) begin
                settle();
                write_bg(rows[i].rgb);
            end else begin
                feed(rows[i].sp, rows[i].has_want, rows[i].rgb);
            end
        end

        // random pixels, one background setting per phase
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                2: bg = rgb(0, 0, 0);
                3: bg = rgb(65535, 0, $urandom_range(0, 65535));
                default: bg = rgb($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
            endcase
            write_bg(bg);
            idle_on = (phase != NUM_PHASES - 1);
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(1, 10);
                px  = $urandom_range(0, 4095);
                py  = $urandom_range(0, 4095);
                if (phase != NUM_PHASES - 1 && $urandom_range(0, 9) == 0) begin
                    idle_on = !idle_on;
                end
                for (int k = 0; k < len; k++) begin
                    feed(rand_splat(px, py, k == len - 1), 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        if (fail_cnt == 0 && pending_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: gaussian_splat_pixel_compositor.f
src/gspc_pkg.sv
src/gspc_front.sv
src/gspc_queue.sv
src/gspc_back.sv
src/gaussian_splat_pixel_compositor.sv
tb/testbench.sv
